// File: hw/rtl/inverse_divisor_sum_lookup_macros.svh
// ----------------------------------------------------------------------------
// Inverse divisor-sum lookup: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef INVERSE_DIVISOR_SUM_LOOKUP_MACROS_SVH
`define INVERSE_DIVISOR_SUM_LOOKUP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ids_pkg.sv
// ----------------------------------------------------------------------------
// Inverse divisor-sum lookup: package
// Fixed field widths and the build-to-lookup interface structure.
// ----------------------------------------------------------------------------
package ids_pkg;

  // Width of the query and result number fields.
  localparam int unsigned QW = 11;

  // Widest table address and number over the supported MAX_N range (up to 4096).
  localparam int unsigned AW_MAX = 13;

  typedef struct packed {
    logic              done;
    logic              wr_en;
    logic [AW_MAX-1:0] wr_addr;
    logic [AW_MAX-1:0] wr_data;
  } ids_build_t;

endpackage

// File: hw/rtl/ids_sieve.sv
// ----------------------------------------------------------------------------
// Inverse divisor-sum lookup: build sieve
// Accumulates sigma(n) in a sum memory by read-modify-write, then emits the
// answer table writes in rising n order.
// ----------------------------------------------------------------------------
module ids_sieve #(
  parameter int unsigned MAX_N = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  output ids_pkg::ids_build_t build_o
);
  import ids_pkg::*;

  localparam int unsigned NW = $clog2(MAX_N + 1);
  localparam int unsigned CW = NW + 1;
  localparam int unsigned SW = $clog2(MAX_N + 2);

  localparam logic [NW-1:0] MAXN_N = NW'(MAX_N);
  localparam logic [CW-1:0] MAXN_C = CW'(MAX_N);
  localparam logic [SW:0]   MAXN_S = (SW + 1)'(MAX_N);
  localparam logic [SW-1:0] SAT_S  = SW'(MAX_N + 1);

  typedef enum logic [2:0] {
    ST_SIEVE = 3'b001,
    ST_FILL  = 3'b010,
    ST_DONE  = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [NW-1:0] d_q, d_d;
  logic [CW-1:0] m_q, m_d;
  logic [NW-1:0] n_q, n_d;

  logic          sv_valid_q, sv_first_q;
  logic [NW-1:0] sv_addr_q, sv_d_q;
  logic          fl_valid_q, fl_last_q;
  logic [NW-1:0] fl_n_q;
  logic          fwd_q, fwd_d;
  logic [SW-1:0] fwd_data_q;
  logic          done_q, done_d;

  logic [SW-1:0] sums_mem [MAX_N+1];
  logic [SW-1:0] sum_rdata_q;

  logic          re;
  logic [NW-1:0] raddr;
  logic [SW-1:0] rd, base, wdata;
  logic [SW:0]   acc;
  logic [CW-1:0] m_sum;
  logic          fill_hit, clear_en;

  always_comb begin
    state_d = state_q;
    d_d     = d_q;
    m_d     = m_q;
    n_d     = n_q;
    m_sum   = m_q + CW'(d_q);
    re      = 1'b0;
    raddr   = '0;
    case (state_q)
      ST_SIEVE: begin
        re    = 1'b1;
        raddr = NW'(m_q);
        if (m_sum > MAXN_C) begin
          if (d_q == MAXN_N) begin
            state_d = ST_FILL;
            n_d     = NW'(1);
          end else begin
            d_d = d_q + NW'(1);
            m_d = CW'(d_q) + CW'(1);
          end
        end else begin
          m_d = m_sum;
        end
      end
      ST_FILL: begin
        re    = 1'b1;
        raddr = n_q;
        if (n_q == MAXN_N) begin
          state_d = ST_DONE;
        end else begin
          n_d = n_q + NW'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
        state_d = ST_DONE;
      end
    endcase
  end

  // The first divisor touches every entry once, so it writes d itself and the
  // sum memory needs no clearing pass.
  always_comb begin
    rd    = fwd_q ? fwd_data_q : sum_rdata_q;
    base  = sv_first_q ? '0 : rd;
    acc   = {1'b0, base} + (SW + 1)'(sv_d_q);
    wdata = (acc > MAXN_S) ? SAT_S : SW'(acc);
    fwd_d = re && sv_valid_q && (raddr == sv_addr_q);
    done_d = done_q | (fl_valid_q & fl_last_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_SIEVE;
      d_q        <= NW'(1);
      m_q        <= CW'(1);
      n_q        <= NW'(1);
      sv_valid_q <= 1'b0;
      fl_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      d_q        <= d_d;
      m_q        <= m_d;
      n_q        <= n_d;
      sv_valid_q <= (state_q == ST_SIEVE);
      fl_valid_q <= (state_q == ST_FILL);
      fwd_q      <= fwd_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sv_addr_q  <= NW'(m_q);
    sv_d_q     <= d_q;
    sv_first_q <= (d_q == NW'(1));
    fl_n_q     <= n_q;
    fl_last_q  <= (n_q == MAXN_N);
    fwd_data_q <= wdata;
  end

  always_ff @(posedge clk_i) begin
    if (sv_valid_q) begin
      sums_mem[sv_addr_q] <= wdata;
    end
    if (re) begin
      sum_rdata_q <= sums_mem[raddr];
    end
  end

  // Answer table: cleared alongside the first sieve pass, filled afterwards.
  assign clear_en = (state_q == ST_SIEVE) && (d_q == NW'(1));
  assign fill_hit = fl_valid_q && (rd != '0) && ({1'b0, rd} <= MAXN_S);

  always_comb begin
    build_o.done    = done_q;
    build_o.wr_en   = clear_en | fill_hit;
    build_o.wr_addr = clear_en ? AW_MAX'(m_q) : AW_MAX'(rd);
    build_o.wr_data = clear_en ? '0 : AW_MAX'(fl_n_q);
  end

endmodule

// File: hw/rtl/ids_lookup.sv
// ----------------------------------------------------------------------------
// Inverse divisor-sum lookup: query path
// Holds the answer table and, once built and while the output is not stalled,
// serves one query per cycle through a read stage and an output register.
// ----------------------------------------------------------------------------
module ids_lookup #(
  parameter int unsigned MAX_N = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ids_pkg::ids_build_t       build_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ids_pkg::QW-1:0]    query_sum_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      found_o,
  output logic [ids_pkg::QW-1:0]    largest_number_o
);
  import ids_pkg::*;

  localparam int unsigned NW = $clog2(MAX_N + 1);
  localparam int unsigned XW = (NW > QW) ? NW : QW;
  localparam logic [XW-1:0] MAXN_X = XW'(MAX_N);

  logic [NW-1:0] ans_mem [MAX_N+1];
  logic [NW-1:0] ans_rdata_q;

  logic          lk_valid_q, lk_inrange_q;
  logic          out_valid_q, found_q;
  logic [QW-1:0] largest_q;

  logic [XW-1:0] q_ext;
  logic          inrange, accept, out_adv, lk_free;

  assign q_ext   = XW'(query_sum_i);
  assign inrange = (q_ext != '0) && (q_ext <= MAXN_X);
  assign out_adv = !out_valid_q || out_ready_i;
  assign lk_free = !lk_valid_q || out_adv;

  assign in_ready_o = build_i.done && lk_free;
  assign accept     = in_valid_i && in_ready_o;

  // Read data stays put while the read stage is stalled.
  always_ff @(posedge clk_i) begin
    if (build_i.wr_en) begin
      ans_mem[NW'(build_i.wr_addr)] <= NW'(build_i.wr_data);
    end
    if (accept) begin
      ans_rdata_q <= ans_mem[NW'(q_ext)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        lk_valid_q <= 1'b1;
      end else if (out_adv) begin
        lk_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= lk_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lk_inrange_q <= inrange;
    end
    if (out_adv && lk_valid_q) begin
      found_q   <= lk_inrange_q && (ans_rdata_q != '0);
      largest_q <= lk_inrange_q ? QW'(ans_rdata_q) : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign largest_number_o = largest_q;

endmodule

// File: hw/rtl/inverse_divisor_sum_lookup.sv
// ----------------------------------------------------------------------------
// Inverse divisor-sum lookup
// Returns the largest N up to MAX_N whose sum of divisors equals the query.
// ----------------------------------------------------------------------------
// Usage: queries arrive on the input channel (in_valid_i, in_ready_o,
// query_sum_i); each gives exactly one result on the output channel
// (out_valid_o, out_ready_i, found_o, largest_number_o). A query of zero or
// above MAX_N, or a sum with no preimage, returns found_o low and zero.
// After reset the block builds its tables and holds in_ready_o low until the
// build finishes. The build first runs a divisor-sum sieve as read-modify-
// write on the sum memory, one multiple per cycle; the answer table is
// cleared during the first sieve pass. A fill pass then writes the answers.
// Once built, a query is one read of the answer memory: the read stage
// registers the table data, the output register then holds the result, and
// one query per cycle is sustained while the receiver takes results.
// When the receiver stalls, the output register holds its result and the
// read stage can still take one more query before in_ready_o falls.
// ----------------------------------------------------------------------------
`include "inverse_divisor_sum_lookup_macros.svh"

module inverse_divisor_sum_lookup #(
  parameter int unsigned MAX_N = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [ids_pkg::QW-1:0] query_sum_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   found_o,
  output logic [ids_pkg::QW-1:0] largest_number_o
);
  import ids_pkg::*;

  ids_build_t build;

  ids_sieve #(
    .MAX_N (MAX_N)
  ) u_sieve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .build_o (build)
  );

  ids_lookup #(
    .MAX_N (MAX_N)
  ) u_lookup (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .build_i          (build),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .query_sum_i      (query_sum_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .largest_number_o (largest_number_o)
  );

  `IDS_ASSERT_SAME(a_query_after_build, in_valid_i && in_ready_o, build.done, "early query")
  `IDS_ASSERT_SAME(a_no_write_after_build, build.done, !build.wr_en, "table written after build")
  `IDS_ASSERT_NEXT(a_build_done_holds, build.done, build.done, "build done flag dropped")
  `IDS_ASSERT_SAME(a_miss_is_zero, out_valid_o && !found_o, ~|largest_number_o, "number on miss")

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Inverse divisor-sum lookup testbench
// Builds its own divisor-sum sieve and answer table, drives queries through
// the valid/ready input with random gaps, and checks every result transfer
// in order against the predicted largest preimage.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_N       = 1024;
  localparam int unsigned QW          = ids_pkg::QW;
  localparam int unsigned RANDOM_QRYS = 1300;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned HOLD_AFTER  = 400;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic          found;
    logic [QW-1:0] number;
  } lookup_result_t;

  class lookup_scoreboard;
    int unsigned    sigma_of [0:MAX_N];
    int unsigned    preimage [0:MAX_N];
    lookup_result_t pending_results[$];
    int unsigned    accepted;
    int unsigned    failures;

    function new();
      for (int n = 0; n <= MAX_N; n++) begin
        sigma_of[n] = 0;
        preimage[n] = 0;
      end
      for (int d = 1; d <= MAX_N; d++)
        for (int m = d; m <= MAX_N; m += d)
          sigma_of[m] += d;
      // Rising order leaves the largest n in each entry.
      for (int n = 1; n <= MAX_N; n++)
        if (sigma_of[n] >= 1 && sigma_of[n] <= MAX_N)
          preimage[sigma_of[n]] = n;
      accepted = 0;
      failures = 0;
    endfunction

    function void note_query(logic [QW-1:0] s);
      lookup_result_t r;
      int unsigned    hit;
      hit = 0;
      if (s >= 1 && s <= MAX_N)
        hit = preimage[s];
      r.found  = (hit != 0);
      r.number = hit[QW-1:0];
      pending_results = {pending_results, r};
      accepted++;
    endfunction

    function void check_result(logic found, logic [QW-1:0] number);
      lookup_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing pending: found %0b number %0d",
                 $time, found, number);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (found !== want.found) begin
        $display("%0t: found expected %0b, got %0b", $time, want.found, found);
        failures++;
      end
      if (number !== want.number) begin
        $display("%0t: largest_number expected %0d, got %0d",
                 $time, want.number, number);
        failures++;
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [QW-1:0] query_sum_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic          found_o;
  logic [QW-1:0] largest_number_o;

  lookup_scoreboard sums_board;
  int unsigned      cycle_count;
  bit               held_off;

  inverse_divisor_sum_lookup #(
    .MAX_N(MAX_N)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .query_sum_i     (query_sum_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .largest_number_o(largest_number_o)
  );

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    query_sum_i = '0;
    out_ready_i = 1'b0;
    cycle_count = 0;
    held_off = 1'b0;
    sums_board = new();
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result transfers are checked as they happen.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sums_board.check_result(found_o, largest_number_o);
  end

  // Mostly short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one query and returns at the falling edge after its transfer.
  task automatic send_query(input logic [QW-1:0] s);
    in_valid_i <= 1'b1;
    query_sum_i <= s;
    do @(posedge clk_i); while (!in_ready_o);
    sums_board.note_query(s);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(input int unsigned gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Random sums: mostly ones that have a preimage, the rest spread across
  // the table and across the whole field.
  function automatic logic [QW-1:0] pick_sum();
    int unsigned r;
    int unsigned s;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      do s = sums_board.sigma_of[$urandom_range(1, MAX_N)]; while (s > MAX_N);
      return s[QW-1:0];
    end
    if (r < 90) return QW'($urandom_range(0, MAX_N));
    return QW'($urandom_range(0, (1 << QW) - 1));
  endfunction

  // Receiver: random ready runs and gaps, with one long hold-off once the
  // pipeline has seen some traffic.
  initial begin
    int unsigned run;
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!held_off && sums_board.accepted >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
        out_ready_i <= 1'b1;
        repeat (run) @(negedge clk_i);
        gap = pick_gap();
        if (gap > 0) begin
          out_ready_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
    end
  end

  initial begin
    logic [QW-1:0] directed_sums[$];
    int unsigned   gap;
    // Zero, out of range, no preimage, several preimages, the table edges
    // and alternating bit patterns.
    directed_sums = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd12, 11'd24, 11'd1024,
                      11'd1025, 11'd2047, 11'd1023, 11'd1000, 11'd1001,
                      11'h555, 11'h2AA, 11'd512, 11'd4, 11'd7, 11'd8,
                      11'd1536, 11'd1022};

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_sums[i]) begin
      send_query(directed_sums[i]);
      idle_sender(pick_gap());
    end

    for (int i = 0; i < RANDOM_QRYS; i++) begin
      // Every fourth block of a hundred runs back to back.
      gap = ((i / 100) % 4 == 1) ? 0 : pick_gap();
      send_query(pick_sum());
      idle_sender(gap);
    end
    in_valid_i <= 1'b0;

    while (sums_board.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sums_board.failures == 0 && sums_board.pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
